[rtl/srrw_pkg.sv]
// ----------------------------------------------------------------------------
// srrw_pkg
// Shared types and constants of the selective-repeat receive window.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int unsigned SEQ_W      = 3;   // sequence number width, space of 8
  localparam int unsigned HOLD_DEPTH = 4;   // reorder buffer entries
  localparam int unsigned CNT_W      = 3;   // holds 0..HOLD_DEPTH
  localparam int unsigned OUT_PAY_W  = 32;  // delivered payload width

  localparam logic KIND_ACK     = 1'b0;
  localparam logic KIND_DELIVER = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // take the packet, insert it, note a previous-window ack
    logic emit_ack;   // present the pending ack
    logic emit_dlv;   // present the buffer head and pop it
    logic last;       // final result of this transaction
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic ack_pend;   // previous-window ack waits
    logic dlv_ready;  // buffer head equals window base
  } dp_status_t;

endpackage

[rtl/srrw_ctrl.sv]
// ----------------------------------------------------------------------------
// srrw_ctrl
// Sequencer: accept, then up to two results.
// ----------------------------------------------------------------------------
module srrw_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  srrw_pkg::dp_status_t   status_i,
  output srrw_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_CHECK   = 3'b010,
    ST_DELIVER = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d      = state_q;
    cmd_o        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (status_i.ack_pend) begin
          cmd_o.emit_ack = 1'b1;
          cmd_o.last     = !status_i.dlv_ready;
          state_d        = status_i.dlv_ready ? ST_DELIVER : ST_IDLE;
        end else if (status_i.dlv_ready) begin
          cmd_o.emit_dlv = 1'b1;
          cmd_o.last     = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DELIVER: begin
        cmd_o.emit_dlv = 1'b1;
        cmd_o.last     = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

[rtl/srrw_dp.sv]
// ----------------------------------------------------------------------------
// srrw_dp
// Window base, sorted reorder buffer and result register.
// ----------------------------------------------------------------------------
module srrw_dp #(
  parameter int unsigned WINDOW_SIZE  = 4,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  srrw_pkg::ctrl_cmd_t            cmd_i,
  output srrw_pkg::dp_status_t           status_o,
  input  logic [srrw_pkg::SEQ_W-1:0]     seq_num_i,
  input  logic                           checksum_ok_i,
  input  logic [PAYLOAD_BITS-1:0]        payload_i,
  output logic                           result_valid_o,
  output logic                           result_kind_o,
  output logic [srrw_pkg::SEQ_W-1:0]     ack_num_o,
  output logic [srrw_pkg::OUT_PAY_W-1:0] delivered_payload_o,
  output logic                           last_o
);

  localparam int unsigned SeqW  = srrw_pkg::SEQ_W;
  localparam int unsigned Depth = srrw_pkg::HOLD_DEPTH;
  localparam int unsigned CntW  = srrw_pkg::CNT_W;
  localparam int unsigned OutW  = srrw_pkg::OUT_PAY_W;

  logic [SeqW-1:0]         base_q, base_d;
  logic [CntW-1:0]         count_q, count_d;
  logic [SeqW-1:0]         hseq_q [Depth];
  logic [SeqW-1:0]         hseq_d [Depth];
  logic [PAYLOAD_BITS-1:0] hpay_q [Depth];
  logic [PAYLOAD_BITS-1:0] hpay_d [Depth];
  logic                    ack_pend_q, ack_pend_d;
  logic [SeqW-1:0]         ack_seq_q, ack_seq_d;
  logic                    live_q, live_d;   // last packet passed full/checksum test

  logic                    res_valid_q, res_kind_q, res_last_q;
  logic [SeqW-1:0]         res_ack_q;
  logic [OutW-1:0]         res_pay_q;

  logic [SeqW-1:0]         off, back;
  logic                    drop, in_win, dup, found;
  logic [CntW-1:0]         pos;
  logic [OutW-1:0]         head_pay;

  // head payload resized to the result width
  if (PAYLOAD_BITS >= OutW) begin : g_trunc
    assign head_pay = hpay_q[0][OutW-1:0];
  end else begin : g_ext
    assign head_pay = {{(OutW - PAYLOAD_BITS){1'b0}}, hpay_q[0]};
  end

  assign off    = seq_num_i - base_q;
  assign back   = base_q - seq_num_i;
  assign drop   = (count_q >= CntW'(Depth)) || !checksum_ok_i;
  assign in_win = (off < SeqW'(WINDOW_SIZE));

  // duplicate check and sorted insert position
  always_comb begin
    dup   = 1'b0;
    found = 1'b0;
    pos   = count_q;
    for (int i = 0; i < Depth; i++) begin
      if (CntW'(i) < count_q) begin
        if (hseq_q[i] == seq_num_i) dup = 1'b1;
        if (!found && ((hseq_q[i] - base_q) > off)) begin
          found = 1'b1;
          pos   = CntW'(i);
        end
      end
    end
  end

  always_comb begin
    base_d     = base_q;
    count_d    = count_q;
    hseq_d     = hseq_q;
    hpay_d     = hpay_q;
    ack_pend_d = ack_pend_q;
    ack_seq_d  = ack_seq_q;
    live_d     = live_q;
    priority if (cmd_i.accept) begin
      live_d     = !drop;
      ack_pend_d = !drop && (back != '0) && (back <= SeqW'(WINDOW_SIZE));
      ack_seq_d  = seq_num_i;
      if (!drop && in_win && !dup) begin
        for (int i = 0; i < Depth; i++) begin
          if (CntW'(i) == pos) begin
            hseq_d[i] = seq_num_i;
            hpay_d[i] = payload_i;
          end else if (CntW'(i) > pos && i > 0) begin
            hseq_d[i] = hseq_q[(i > 0) ? i - 1 : 0];
            hpay_d[i] = hpay_q[(i > 0) ? i - 1 : 0];
          end
        end
        count_d = count_q + CntW'(1);
      end
    end else if (cmd_i.emit_dlv) begin
      for (int i = 0; i < Depth - 1; i++) begin
        hseq_d[i] = hseq_q[i + 1];
        hpay_d[i] = hpay_q[i + 1];
      end
      count_d = count_q - CntW'(1);
      base_d  = base_q + SeqW'(1);
    end else if (cmd_i.emit_ack) begin
      ack_pend_d = 1'b0;
    end else begin
      ack_pend_d = ack_pend_q;
    end
  end

  // a dropped packet causes no delivery either
  assign status_o.ack_pend  = ack_pend_q;
  assign status_o.dlv_ready = live_q && (count_q != '0) && (hseq_q[0] == base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      count_q     <= '0;
      ack_pend_q  <= 1'b0;
      live_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      count_q     <= count_d;
      ack_pend_q  <= ack_pend_d;
      live_q      <= live_d;
      res_valid_q <= cmd_i.emit_ack | cmd_i.emit_dlv;
    end
  end

  always_ff @(posedge clk_i) begin
    hseq_q    <= hseq_d;
    hpay_q    <= hpay_d;
    ack_seq_q <= ack_seq_d;
    if (cmd_i.emit_ack) begin
      res_kind_q <= srrw_pkg::KIND_ACK;
      res_ack_q  <= ack_seq_q;
      res_pay_q  <= '0;
      res_last_q <= cmd_i.last;
    end else if (cmd_i.emit_dlv) begin
      res_kind_q <= srrw_pkg::KIND_DELIVER;
      res_ack_q  <= hseq_q[0];
      res_pay_q  <= head_pay;
      res_last_q <= cmd_i.last;
    end
  end

  assign result_valid_o      = res_valid_q;
  assign result_kind_o       = res_kind_q;
  assign ack_num_o           = res_ack_q;
  assign delivered_payload_o = res_pay_q;
  assign last_o              = res_last_q;

endmodule

[rtl/selective_repeat_receive_window.sv]
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Selective-repeat receiver: 3-bit sequence space, reorder buffer of four.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a packet transaction is taken at a rising edge with start high
//   and busy low (seq_num_i, checksum_ok_i, payload_i sampled there).
//   Output: each result is shown for exactly one cycle with result_valid_o
//   high; the receiver cannot stall, so nothing is held back.
// Sequence:
//   The accept edge checks the packet and inserts it in the sorted buffer.
//   The first result is decided in the check state and registered; a
//   second result (a delivery after a previous-window ack) follows in
//   the next cycle. A packet keeps busy high through the check state and,
//   for two results, the deliver state; busy is low again in the cycle in
//   which the final result is shown, so the next packet may be taken then.
//   The rate is set by the controller's sequence: insert, ack, deliver.
// Reset:
//   rst_ni (async, active low) clears window base, fill count, pending ack
//   and the result strobe. Buffer entries are not cleared; only entries
//   below the fill count are ever used.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
  parameter int unsigned WINDOW_SIZE  = 4,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [srrw_pkg::SEQ_W-1:0]     seq_num_i,
  input  logic                           checksum_ok_i,
  input  logic [PAYLOAD_BITS-1:0]        payload_i,
  output logic                           result_valid_o,
  output logic                           result_kind_o,
  output logic [srrw_pkg::SEQ_W-1:0]     ack_num_o,
  output logic [srrw_pkg::OUT_PAY_W-1:0] delivered_payload_o,
  output logic                           last_o
);

  srrw_pkg::ctrl_cmd_t  cmd;
  srrw_pkg::dp_status_t status;

  // sequencer: accept, then an ack and/or a delivery
  srrw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // window state, reorder buffer and registered result
  srrw_dp #(
    .WINDOW_SIZE  (WINDOW_SIZE),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .seq_num_i           (seq_num_i),
    .checksum_ok_i       (checksum_ok_i),
    .payload_i           (payload_i),
    .result_valid_o      (result_valid_o),
    .result_kind_o       (result_kind_o),
    .ack_num_o           (ack_num_o),
    .delivered_payload_o (delivered_payload_o),
    .last_o              (last_o)
  );

endmodule
